/* src/aip_pkg.sv */
// Package for the ASCII integer parser: character codes, radix values and register indexes.
package aip_pkg;

    // Character codes recognized by the parser
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'
    localparam logic [7:0] CH_UP_B  = 8'h42;  // 'B'
    localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'

    // Radix values
    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_BIN  = 5'd2;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    // Register indexes (paddr[2])
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

endpackage

/* src/ascii_integer_parser.sv */
// ASCII integer parser: one character per item in, one parsed integer per number out.
//
// Usage:
//   s_ channel: one character per item. s_tdata[7:0] is the character code,
//   s_tuser marks the first character of a string and restarts the parse.
//   m_ channel: one item per parsed number. m_tdata[31:0] is the value
//   (two's complement after a minus in signed mode), m_tdata[39:32] the count
//   of characters consumed (sign, prefix, digits), saturating at 255.
//   APB port: register 0 (address 0) is number_base, 0 selects 0x/0b prefix
//   detection with a fallback to base ten; register 1 (address 4) is
//   signed_mode. Write configuration only while the block is idle.
// Throughput: one item per cycle while s_tready is high; the whole parse step for
//   a character is one multiply by the base and an add, between the state registers.
// Output: the result of the character that ends a number is registered on m_, or
//   parked in the skid entry while the receiver stalls.
// Reset: the parser waits for a first character; number_base resets to 0 and
//   signed_mode to 1. Output and skid stages are emptied.
// Stall: while a result waits, s_tready stays high until a second result is
//   parked in the skid entry, then stays low until the edge at which the
//   receiver takes the waiting result and the skid entry moves up.
module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] first_char
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value_bits, [39:32] used_count
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_ZERO,
        PH_MARK,
        PH_DIGIT,
        PH_DONE
    } phase_t;

    // Configuration registers
    logic [4:0] number_base_reg;
    logic       signed_mode_reg;

    // Parse state
    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    minus_reg, minus_next;
    logic [4:0]              base_reg, base_next;
    logic [7:0]              cnt_reg, cnt_next;

    // Output register and skid entry
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        skid_valid_reg;
    logic [39:0] skid_data_reg;

    // Per-character step
    logic                  accept;
    logic                  cfg_write;
    logic [7:0]            ch;
    phase_t                cur;
    logic                  stop;
    logic                  take;
    logic                  emit;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] acc_eff;
    logic [7:0]            cnt_eff;
    logic [VALUE_BITS+4:0] product;
    logic [VALUE_BITS-1:0] signed_val;
    logic [39:0]           result;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !skid_valid_reg;
    assign ch        = s_tdata;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_NUMBER_BASE: prdata = {27'd0, number_base_reg};
            REG_SIGNED_MODE: prdata = {31'd0, signed_mode_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Walk the phases for one character; several may pass in one step.
    always_comb begin
        cur        = s_tuser ? PH_SIGN : phase_reg;
        acc_eff    = s_tuser ? '0 : acc_reg;
        cnt_eff    = s_tuser ? 8'd0 : cnt_reg;
        minus_next = s_tuser ? 1'b0 : minus_reg;
        base_next  = s_tuser ? number_base_reg : base_reg;
        phase_next = cur;
        acc_next   = acc_eff;
        stop       = 1'b0;
        take       = 1'b0;
        emit       = 1'b0;
        is_digit   = 1'b0;
        digit      = 4'd0;
        product    = '0;

        if (cur == PH_SIGN) begin
            if (signed_mode_reg && (ch == CH_MINUS || ch == CH_PLUS)) begin
                minus_next = (ch == CH_MINUS);
                take       = 1'b1;
                phase_next = PH_ZERO;
                stop       = 1'b1;
            end else begin
                cur = PH_ZERO;
            end
        end

        if (!stop && cur == PH_ZERO) begin
            if (ch == CH_ZERO && base_next == BASE_AUTO) begin
                take       = 1'b1;
                phase_next = PH_MARK;
                stop       = 1'b1;
            end else begin
                if (base_next == BASE_AUTO) begin
                    base_next = BASE_DEC;
                end
                cur = PH_DIGIT;
            end
        end

        if (!stop && cur == PH_MARK) begin
            if (ch == CH_LO_X || ch == CH_UP_X) begin
                base_next  = BASE_HEX;
                take       = 1'b1;
                phase_next = PH_DIGIT;
                stop       = 1'b1;
            end else if (ch == CH_LO_B || ch == CH_UP_B) begin
                base_next  = BASE_BIN;
                take       = 1'b1;
                phase_next = PH_DIGIT;
                stop       = 1'b1;
            end else begin
                base_next = BASE_DEC;
                cur       = PH_DIGIT;
            end
        end

        if (!stop && cur == PH_DIGIT) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                is_digit = 1'b1;
                digit    = 4'(ch - CH_ZERO);
            end else if (base_next > BASE_DEC && ch >= CH_UP_A && ch <= CH_UP_F) begin
                is_digit = 1'b1;
                digit    = 4'(ch - CH_UP_A + 8'd10);
            end else if (base_next > BASE_DEC && ch >= CH_LO_A && ch <= CH_LO_F) begin
                is_digit = 1'b1;
                digit    = 4'(ch - CH_LO_A + 8'd10);
            end
            if (is_digit) begin
                product    = (VALUE_BITS+5)'(acc_eff) * (VALUE_BITS+5)'(base_next);
                acc_next   = VALUE_BITS'(product) + VALUE_BITS'(digit);
                take       = 1'b1;
                phase_next = PH_DIGIT;
            end else begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end

        cnt_next = (take && cnt_eff != COUNT_MAX) ? cnt_eff + 8'd1 : cnt_eff;
    end

    assign signed_val = minus_next ? (~acc_eff + VALUE_BITS'(1)) : acc_eff;
    assign result     = {cnt_eff, 32'(signed_val)};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_AUTO;
            signed_mode_reg <= 1'b1;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_NUMBER_BASE: number_base_reg <= pwdata[4:0];
                REG_SIGNED_MODE: signed_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Parse state: advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            base_reg  <= BASE_AUTO;
            cnt_reg   <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                // Drain the skid entry first; input is held off meanwhile
                m_valid_reg    <= 1'b1;
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= accept && emit;
                m_data_reg  <= result;
            end
        end else if (accept && emit) begin
            // Receiver stalled: park the new result
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= result;
        end
    end

endmodule

/* bench/ascii_integer_parser_tb.sv */
// Self-checking bench for the streaming integer parser: directed script, random strings, receiver hold-off.
`timescale 1ns / 100ps

module ascii_integer_parser_tb;
    import aip_pkg::*;

    // Bench sizing: no-progress watchdog, receiver hold-off, items per random phase, phase count, settle wait
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 85;
    localparam int RANDOM_PHASES = 12;
    localparam int SETTLE_CYCLES = 4;

    // Idle profiles, cycled over the random phases: none, sender, receiver, both
    localparam int TX_IDLE  [4] = '{0, 79, 0, 33};
    localparam int RX_STALL [4] = '{0, 0, 79, 33};

    // Register settings for the first random phases, extremes first; later ones random
    localparam logic [4:0] RADIX_PLAN [6] = '{BASE_AUTO, 5'd31, BASE_HEX, 5'd1, BASE_BIN,
                                              BASE_DEC};
    localparam logic       SIGN_PLAN  [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    // Parser scan states
    typedef enum logic [2:0] {
        SCAN_SIGN, SCAN_LEAD_ZERO, SCAN_RADIX_MARK, SCAN_DIGITS, SCAN_IDLE
    } scan_t;

    // One parsed number, laid out as on m_tdata
    typedef struct packed {
        logic [7:0]  count;
        logic [31:0] value;
    } number_t;

    typedef enum logic [1:0] {ROW_CHAR, ROW_RADIX, ROW_SIGN} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;       // character, or register value for a register row
        logic        first;
        logic        pinned;     // expected number typed in below
        logic [31:0] pin_value;
        logic [7:0]  pin_count;
    } script_row_t;

    localparam int SCRIPT_LEN = 28;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{ROW_CHAR,  "Z",      1'b0, 1'b0, 32'h0,         8'd0},  // nothing started: ignored
        '{ROW_CHAR,  CH_MINUS, 1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_ZERO,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_LO_X,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_LO_F,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  8'h00,    1'b0, 1'b1, 32'hFFFF_FFF1, 8'd4},  // "-0xf": minus fifteen
        '{ROW_CHAR,  CH_ZERO,  1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_LO_B,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  "1",      1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  "2",      1'b0, 1'b0, 32'h0,         8'd0},  // above base two, still taken
        '{ROW_CHAR,  CH_PLUS,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_ZERO,  1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_UP_X,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  "G",      1'b0, 1'b1, 32'h0,         8'd2},  // prefix with no digits
        '{ROW_CHAR,  "8",      1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_ZERO,  1'b1, 1'b0, 32'h0,         8'd0},  // restart drops "8"
        '{ROW_CHAR,  "7",      1'b0, 1'b0, 32'h0,         8'd0},  // lone zero, then base ten
        '{ROW_CHAR,  8'hFF,    1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_RADIX, 8'(BASE_HEX), 1'b0, 1'b0, 32'h0,     8'd0},
        '{ROW_SIGN,  8'd0,     1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_MINUS, 1'b1, 1'b1, 32'h0,         8'd0},  // sign is a non-digit here
        '{ROW_CHAR,  CH_LO_A,  1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_UP_F,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  CH_PLUS,  1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_RADIX, 8'd1,     1'b0, 1'b0, 32'h0,         8'd0},  // base one, used as given
        '{ROW_CHAR,  "9",      1'b1, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  "9",      1'b0, 1'b0, 32'h0,         8'd0},
        '{ROW_CHAR,  8'h00,    1'b0, 1'b0, 32'h0,         8'd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
    logic        s_tuser  = 1'b0;    // [0] first_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] value_bits, [39:32] used_count
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Parser state as the bench predicts it, and its copy of the registers
    logic [31:0] run_value  = 32'd0;
    scan_t       run_scan   = SCAN_IDLE;
    logic        run_minus  = 1'b0;
    logic [4:0]  run_radix  = 5'd0;
    logic [7:0]  run_used   = 8'd0;
    logic [4:0]  cfg_radix  = BASE_AUTO;
    logic        cfg_signed = 1'b1;

    number_t     number_q [$];       // parsed numbers still to come out of m_
    int          fault_count = 0;
    int          live_items = 0;     // items that reach the parser, not ignored ones
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        rx_hold = 1'b0;
    logic        hold_start = 1'b0;
    int          quiet_cycles = 0;

    ascii_integer_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Advance the predicted parser by one character; return 1 when a number ends here.
    // The scan states fall through in order, so a character can pass several of them.
    function automatic bit scan_char(input logic [7:0] ch, input logic first,
                                     output number_t num);
        logic [7:0] digit;
        num = '0;
        if (first) begin
            run_value = 32'd0;
            run_minus = 1'b0;
            run_radix = cfg_radix;   // base is latched at the first character
            run_used  = 8'd0;
            run_scan  = SCAN_SIGN;
        end
        if (run_scan == SCAN_SIGN) begin
            // signed mode is read live, right here
            if (cfg_signed && (ch == CH_MINUS || ch == CH_PLUS)) begin
                if (ch == CH_MINUS) run_minus = 1'b1;
                run_used += 8'(run_used != COUNT_MAX);
                run_scan = SCAN_LEAD_ZERO;
                return 1'b0;
            end
            run_scan = SCAN_LEAD_ZERO;
        end
        if (run_scan == SCAN_LEAD_ZERO) begin
            if (ch == CH_ZERO && run_radix == BASE_AUTO) begin
                run_used += 8'(run_used != COUNT_MAX);
                run_scan = SCAN_RADIX_MARK;
                return 1'b0;
            end
            if (run_radix == BASE_AUTO) run_radix = BASE_DEC;
            run_scan = SCAN_DIGITS;
        end else if (run_scan == SCAN_RADIX_MARK) begin
            run_scan = SCAN_DIGITS;
            if (ch == CH_LO_X || ch == CH_UP_X) begin
                run_radix = BASE_HEX;
                run_used += 8'(run_used != COUNT_MAX);
                return 1'b0;
            end
            if (ch == CH_LO_B || ch == CH_UP_B) begin
                run_radix = BASE_BIN;
                run_used += 8'(run_used != COUNT_MAX);
                return 1'b0;
            end
            run_radix = BASE_DEC;
        end
        if (run_scan == SCAN_DIGITS) begin
            // digits are not checked against the base; letters count above base ten
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                digit = ch - CH_ZERO;
            end else if (run_radix > BASE_DEC && ch >= CH_UP_A && ch <= CH_UP_F) begin
                digit = ch - CH_UP_A + 8'd10;
            end else if (run_radix > BASE_DEC && ch >= CH_LO_A && ch <= CH_LO_F) begin
                digit = ch - CH_LO_A + 8'd10;
            end else begin
                num.value = run_minus ? 32'd0 - run_value : run_value;
                num.count = run_used;
                run_scan  = SCAN_IDLE;
                return 1'b1;
            end
            run_value = run_value * run_radix + digit;
            run_used += 8'(run_used != COUNT_MAX);
        end
        return 1'b0;
    endfunction

    // Offer one character, idling first at the sender's rate; predict once it is taken.
    task automatic send_char(input logic [7:0] ch, input logic first,
                             input bit pinned = 1'b0, input number_t pin = '0);
        number_t num;
        bit      ends;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        if (first || run_scan != SCAN_IDLE) live_items++;
        ends = scan_char(ch, first, num);
        if (pinned) number_q.push_back(pin);
        else if (ends) number_q.push_back(num);
    endtask

    // Drop valid, drain every expected number, then allow the parser's latency to pass
    task automatic settle();
        s_tvalid <= 1'b0;
        while (number_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_reg(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_NUMBER_BASE) cfg_radix = data[4:0];
        else cfg_signed = data[0];
    endtask

    // One random string: mostly well formed (sign, prefix, digits, terminator),
    // some cut short so the next first character drops them, some plain noise.
    task automatic send_random_string(input bit want_long);
        logic [7:0]  text [$];
        logic [7:0]  c;
        int unsigned pick;
        int unsigned roll;
        int unsigned ndig;
        bit          hexy;
        pick = $urandom_range(99);
        if (!want_long && pick < 12) begin
            repeat ($urandom_range(6, 1)) send_char(8'($urandom()), $urandom_range(3) == 0);
            return;
        end
        hexy = cfg_radix > BASE_DEC;
        if ($urandom_range(99) < (cfg_signed ? 50 : 10))
            text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        if (cfg_radix == BASE_AUTO && $urandom_range(99) < 50) begin
            text.push_back(CH_ZERO);
            case ($urandom_range(4))
                0: begin
                    text.push_back(CH_LO_X);
                    hexy = 1'b1;
                end
                1: begin
                    text.push_back(CH_UP_X);
                    hexy = 1'b1;
                end
                2: text.push_back(CH_LO_B);
                3: text.push_back(CH_UP_B);
                default: ;   // lone zero
            endcase
        end
        // long runs wrap the value and saturate the count
        ndig = want_long ? $urandom_range(270, 256) : $urandom_range(12);
        repeat (ndig) begin
            roll = $urandom_range(hexy ? 21 : 9);
            if (roll < 10) c = CH_ZERO + 8'(roll);
            else if (roll < 16) c = CH_LO_A + 8'(roll - 10);
            else c = CH_UP_A + 8'(roll - 16);
            text.push_back(c);
        end
        if (want_long || pick >= 22) begin
            case ($urandom_range(5))
                0: c = 8'h00;
                1: c = " ";
                2: c = 8'hFF;
                3: c = "g";
                4: c = CH_MINUS;
                default: c = 8'($urandom());
            endcase
            text.push_back(c);
        end
        foreach (text[i]) send_char(text[i], i == 0);
        // trailing characters, ignored once the number has ended
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) send_char(8'($urandom()), 1'b0);
    endtask

    // Result side: check each accepted number, then pick next cycle's ready
    always @(posedge aclk) begin : result_check
        number_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (number_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: value %h count %0d",
                             m_tdata[31:0], m_tdata[39:32]);
            end else begin
                want = number_q.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("value_bits mismatch: expected %h, got %h",
                                 want.value, m_tdata[31:0]);
                end
                if (m_tdata[39:32] !== want.count) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("used_count mismatch: expected %0d, got %0d",
                                 want.count, m_tdata[39:32]);
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        wait (hold_start);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("ascii_integer_parser_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        script_row_t row;
        logic [4:0]  radix;
        logic        sign_on;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script, starting from the reset register values
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = SCRIPT[i];
            case (row.kind)
                ROW_RADIX: begin
                    settle();
                    write_reg(REG_NUMBER_BASE, {24'd0, row.data});
                end
                ROW_SIGN: begin
                    settle();
                    write_reg(REG_SIGNED_MODE, {24'd0, row.data});
                end
                default: begin
                    send_char(row.data, row.first, row.pinned, {row.pin_count, row.pin_value});
                end
            endcase
        end

        // Random phases: new registers each time, idle profile cycled
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            if (ph < 6) begin
                radix   = RADIX_PLAN[ph];
                sign_on = SIGN_PLAN[ph];
            end else begin
                radix   = $urandom_range(1) ? BASE_AUTO : 5'($urandom_range(31));
                sign_on = 1'($urandom_range(1));
            end
            write_reg(REG_NUMBER_BASE, {27'd0, radix});
            write_reg(REG_SIGNED_MODE, {31'd0, sign_on});
            tx_idle_pct  = TX_IDLE[ph % 4];
            rx_stall_pct = RX_STALL[ph % 4];
            live_items   = 0;
            if (ph == 7) send_random_string(1'b1);
            while (live_items < PHASE_ITEMS) send_random_string(1'b0);
        end

        // Pressure: hold the receiver off while short numbers keep coming, so the
        // output fills and s_tready drops
        settle();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_start   = 1'b1;
        repeat (40) begin
            send_char(CH_ZERO + 8'($urandom_range(9)), 1'b1);
            send_char(" ", 1'b0);
        end

        settle();
        if (fault_count == 0) begin
            $display("ascii_integer_parser_tb OK");
        end else begin
            $display("ascii_integer_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
